>>> design/bbf_pkg.sv
// Package for the blocked Bloom filter: widths, function codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bbf_pkg;

    localparam int MAX_WORDS   = 1024;
    localparam int ADDR_W      = $clog2(MAX_WORDS);
    localparam int WORD_W      = 64;
    localparam int KEY_W       = 64;
    localparam int FUNC_W      = 3;
    localparam int SIZE_W      = 4;
    localparam int POS_W       = 6;
    localparam int KEY_IDX_LSB = 24;
    localparam int SIZE_MIN    = 2;
    localparam int SIZE_MAX    = ADDR_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(10);

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_QUERY  = 3'd1,
        FN_WRITE  = 3'd2,
        FN_MERGE  = 3'd3,
        FN_READ   = 3'd4
    } t_func;

    // Controller to datapath
    typedef struct packed {
        logic clr;     // zero the word at the clear pointer
        logic accept;  // latch the input beat
        logic rd;      // read the addressed word
        logic exec;    // update word (insert/write/merge), load result reg
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last; // clear pointer at the final word
    } t_sts;

endpackage

>>> design/bbf_in_if.sv
// Input channel of the blocked Bloom filter: valid/ready plus request payload.
// Depends on bbf_pkg.
`timescale 1ns / 1ps

interface bbf_in_if;
    logic                         valid;
    logic                         ready;
    logic [bbf_pkg::FUNC_W-1:0]   func;
    logic [bbf_pkg::KEY_W-1:0]    key;
    logic [bbf_pkg::ADDR_W-1:0]   word_index;
    logic [bbf_pkg::WORD_W-1:0]   word_value;

    modport source (output valid, func, key, word_index, word_value, input ready);
    modport sink   (input valid, func, key, word_index, word_value, output ready);
endinterface

>>> design/bbf_out_if.sv
// Output channel of the blocked Bloom filter: valid/ready plus result payload.
// Depends on bbf_pkg.
`timescale 1ns / 1ps

interface bbf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         flag;
    logic [bbf_pkg::WORD_W-1:0]   word_data;

    modport source (output valid, flag, word_data, input ready);
    modport sink   (input valid, flag, word_data, output ready);
endinterface

>>> design/bbf_ctrl.sv
// Controller of the blocked Bloom filter: clear pass, then accept/read/update
// sequencing and the result valid flag. Depends on bbf_pkg.
`timescale 1ns / 1ps

module bbf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bbf_pkg::t_cmd o_cmd,
    input  bbf_pkg::t_sts i_sts
);
    import bbf_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                // hold until the result register is free
                if (slot_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input accepted during clear pass");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_accept_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_cmd.rd)
        else $error("accepted beat not followed by store read");

    a_read_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> (r_state == S_EXEC))
        else $error("store read not followed by update");
`endif

endmodule

>>> design/bbf_dpath.sv
// Datapath of the blocked Bloom filter: size register, request latch, key mask,
// filter word store with clear pointer, and result register. Depends on bbf_pkg.
`timescale 1ns / 1ps

module bbf_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bbf_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  bbf_pkg::t_cmd                 i_cmd,
    output bbf_pkg::t_sts                 o_sts,
    input  logic [bbf_pkg::FUNC_W-1:0]    i_func,
    input  logic [bbf_pkg::KEY_W-1:0]     i_key,
    input  logic [bbf_pkg::ADDR_W-1:0]    i_word_index,
    input  logic [bbf_pkg::WORD_W-1:0]    i_word_value,
    output logic                          o_flag,
    output logic [bbf_pkg::WORD_W-1:0]    o_word_data
);
    import bbf_pkg::*;

    logic [WORD_W-1:0] mem [MAX_WORDS];

    logic [SIZE_W-1:0] r_size_log2;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [FUNC_W-1:0] r_func;
    logic [WORD_W-1:0] r_mask;
    logic [WORD_W-1:0] r_value;
    logic [ADDR_W-1:0] r_addr;
    logic [WORD_W-1:0] r_rdata;
    logic              r_flag;
    logic [WORD_W-1:0] r_word_data;

    logic [SIZE_W-1:0] eff_log2;
    logic [ADDR_W-1:0] sel;
    logic [ADDR_W-1:0] n_addr;
    logic [WORD_W-1:0] n_mask;
    logic              n_flag;
    logic [WORD_W-1:0] n_word_data;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic              hit_all;

    // Clamp the size to the store and build the address mask
    always_comb begin
        if (r_size_log2 < SIZE_W'(SIZE_MIN)) begin
            eff_log2 = SIZE_W'(SIZE_MIN);
        end else if (r_size_log2 > SIZE_W'(SIZE_MAX)) begin
            eff_log2 = SIZE_W'(SIZE_MAX);
        end else begin
            eff_log2 = r_size_log2;
        end
        for (int i = 0; i < ADDR_W; i++) begin
            sel[i] = (SIZE_W'(i) < eff_log2);
        end
    end

    always_comb begin
        if (i_func == FN_INSERT || i_func == FN_QUERY) begin
            n_addr = i_key[KEY_IDX_LSB +: ADDR_W] & sel;
        end else begin
            n_addr = i_word_index & sel;
        end
        n_mask = (WORD_W'(1) << i_key[0*POS_W +: POS_W])
               | (WORD_W'(1) << i_key[1*POS_W +: POS_W])
               | (WORD_W'(1) << i_key[2*POS_W +: POS_W])
               | (WORD_W'(1) << i_key[3*POS_W +: POS_W]);
    end

    assign hit_all = ((r_rdata & r_mask) == r_mask);

    always_comb begin
        n_flag      = 1'b0;
        n_word_data = '0;
        wr_en       = 1'b0;
        wr_data     = r_rdata;
        unique case (r_func)
            FN_INSERT: begin
                n_flag  = !hit_all;
                wr_en   = 1'b1;
                wr_data = r_rdata | r_mask;
            end
            FN_QUERY: begin
                n_flag = hit_all;
            end
            FN_WRITE: begin
                wr_en   = 1'b1;
                wr_data = r_value;
            end
            FN_MERGE: begin
                wr_en   = 1'b1;
                wr_data = r_rdata | r_value;
            end
            FN_READ: begin
                n_word_data = r_rdata;
            end
            default: begin
                n_flag = 1'b0;
            end
        endcase
    end

    assign o_sts.clr_last = (r_clr_addr == ADDR_W'(MAX_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= SIZE_RESET;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size_log2 <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.exec && wr_en) begin
            mem[r_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_mask  <= n_mask;
            r_value <= i_word_value;
            r_addr  <= n_addr;
        end
        if (i_cmd.exec) begin
            r_flag      <= n_flag;
            r_word_data <= n_word_data;
        end
    end

    assign o_flag      = r_flag;
    assign o_word_data = r_word_data;

endmodule

>>> design/blocked_bloom_filter.sv
// Top level of the blocked Bloom filter: ties controller and datapath to the
// request and result channels. Depends on bbf_pkg, bbf_in_if, bbf_out_if, bbf_ctrl, bbf_dpath.
`timescale 1ns / 1ps

// A register-blocked Bloom filter over a store of 1024 64-bit words, of which
// 2^size_log2 (clamped to 4..1024) are in use. Each request beat carries a
// function: insert and query take a 64-bit hash whose four low 6-bit fields
// pick the bits of a mask and whose bits from 24 up pick the word; write,
// merge and read address a word directly through word_index, wrapped to the
// words in use. Every request yields one result beat (flag, word_data).
// After reset the block zeroes the store, one word a cycle, and holds ready
// low meanwhile; size writes are taken at any time. Each item then passes
// through accept, store read, and update with result load, in that order,
// a read-modify-write through the single store with its registered read
// port; a new beat is accepted while the last result still waits, and the
// update stalls only while that result is untaken.
module blocked_bloom_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bbf_pkg::SIZE_W-1:0] i_cfg_wdata,
    bbf_in_if.sink                     i_req,
    bbf_out_if.source                  o_rsp
);
    import bbf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence the clear pass and each request beat
    bbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Hold the store, the size register and the result register
    bbf_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_req.func),
        .i_key        (i_req.key),
        .i_word_index (i_req.word_index),
        .i_word_value (i_req.word_value),
        .o_flag       (o_rsp.flag),
        .o_word_data  (o_rsp.word_data)
    );

endmodule
